/* rtl/hkrt_pkg.sv */
// Package for the held-key repeat timer: widths, codes, reset values, entry type.
package hkrt_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned MODS_W = 16;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CFG_W  = 16;

  localparam int unsigned TABLE_ENTRIES_DEF = 8;
  localparam int unsigned MAX_RESULTS       = 8;

  localparam logic [CNT_W-1:0] DELAY_RESET  = 16'd300;
  localparam logic [CNT_W-1:0] PERIOD_RESET = 16'd40;

  // input tdata: key_code, key_modifiers, repeatable, padded to bytes
  localparam int unsigned IN_DATA_W  = 56;
  // output tdata: fired_key, fired_modifiers
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_TICK    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic {
    CFG_DELAY  = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MODS_W-1:0] mods;
    logic [CNT_W-1:0]  cnt;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MODS_W-1:0] mods;
  } fire_t;

endpackage

/* rtl/held_key_repeat_timer.sv */
// Top level of the held-key repeat timer: table memory, scan sequencer, output register.
//
// Auto-repeat timer for held keys. Items come in on the s_axis channel:
// tuser carries the operation (press, release, millisecond tick, clear all),
// tdata carries key code, modifiers and the repeatable flag. Repeat events
// leave on the m_axis channel, one item per firing key in table order, up to
// MAX_RESULTS per tick, with tlast set on the final event of a tick. Press,
// release and clear give no output item.
// Timing: press and clear finish in the accept cycle. A release scans the
// table with a read state and a compare state per entry, then a read and a
// write state move the last entry into the freed slot. A tick visits each
// held entry with a read state and an update state, then a flush state.
// The pace is set by the table's registered read. s_axis_tready is low for
// the whole operation.
// A firing entry is held in a pending register until the next firing entry
// or the end of the scan shows whether it is the last one; it then moves to
// the output register. If the receiver stalls, the scan waits at the next
// firing entry; the output register lets the block take a new item while a
// result still waits.
// Reset empties the table (count to zero) and loads delay 300 and period 40.
// The table contents themselves have no reset; only entries below the count
// are ever read. Configuration writes are taken at any edge with cfg_we_i.
module held_key_repeat_timer
  import hkrt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  // input items
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key_code[31:0], key_modifiers[47:32],
                                               // repeatable[48], zero pad
  input  logic [OP_W-1:0]       s_axis_tuser,  // op[1:0]
  // result items
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // fired_key[31:0], fired_modifiers[47:32]
  output logic                  m_axis_tlast   // last_fired
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned HC_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned NF_W  = $clog2(MAX_RESULTS + 1);
  localparam logic [HC_W-1:0] FULL_COUNT = HC_W'(TABLE_ENTRIES);
  localparam logic [NF_W-1:0] MAX_FIRE   = NF_W'(MAX_RESULTS);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_REL_RD  = 8'b0000_0010,
    ST_REL_EX  = 8'b0000_0100,
    ST_MOVE_RD = 8'b0000_1000,
    ST_MOVE_WR = 8'b0001_0000,
    ST_TICK_RD = 8'b0010_0000,
    ST_TICK_EX = 8'b0100_0000,
    ST_FLUSH   = 8'b1000_0000
  } state_e;

  // ---------------------------------------------------------------- fields
  logic              in_accept;
  op_e               in_op;
  logic [KEY_W-1:0]  in_key;
  logic [MODS_W-1:0] in_mods;
  logic              in_rep;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_op     = op_e'(s_axis_tuser);
  assign in_key    = s_axis_tdata[KEY_W-1:0];
  assign in_mods   = s_axis_tdata[KEY_W+MODS_W-1:KEY_W];
  assign in_rep    = s_axis_tdata[KEY_W+MODS_W];

  // ---------------------------------------------------------------- state
  state_e            state_q, state_d;
  logic [HC_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [NF_W-1:0]   nfire_q, nfire_d;
  logic [KEY_W-1:0]  rel_key_q, rel_key_d;
  logic [CNT_W-1:0]  delay_q, period_q;
  logic              pend_v_q, pend_v_d;
  fire_t             pend_q, pend_d;
  logic              out_v_q, out_v_d;
  fire_t             out_q, out_d;
  logic              out_last_q, out_last_d;

  // table memory: one write, one registered read per cycle
  entry_t            mem_q [TABLE_ENTRIES];
  entry_t            rd_q;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  entry_t            mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic             out_busy;
  logic             scan_last;
  logic             fires;
  logic [IDX_W-1:0] last_idx;

  assign out_busy  = out_v_q && !m_axis_tready;
  assign scan_last = ((HC_W'(idx_q) + HC_W'(1)) == count_q);
  assign fires     = (rd_q.cnt <= CNT_W'(1));
  assign last_idx  = IDX_W'(count_q - HC_W'(1));

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    nfire_d    = nfire_q;
    rel_key_d  = rel_key_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    out_last_d = out_last_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !m_axis_tready;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = idx_q;
    mem_raddr  = idx_q;
    mem_wdata  = rd_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = '0;
          nfire_d = '0;
          case (in_op)
            OP_PRESS: begin
              if (in_rep && (count_q < FULL_COUNT)) begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(count_q);
                mem_wdata = '{key: in_key, mods: in_mods, cnt: delay_q};
                count_d   = count_q + HC_W'(1);
              end
            end
            OP_RELEASE: begin
              rel_key_d = in_key;
              if (count_q != '0) begin
                state_d = ST_REL_RD;
              end
            end
            OP_TICK: begin
              if (count_q != '0) begin
                state_d = ST_TICK_RD;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
              count_d = count_q;
            end
          endcase
        end
      end

      ST_REL_RD: begin
        mem_re  = 1'b1;
        state_d = ST_REL_EX;
      end

      ST_REL_EX: begin
        if (rd_q.key == rel_key_q) begin
          state_d = ST_MOVE_RD;
        end else if (scan_last) begin
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + IDX_W'(1);
          state_d = ST_REL_RD;
        end
      end

      ST_MOVE_RD: begin
        // fetch the last entry to fill the freed slot
        mem_re    = 1'b1;
        mem_raddr = last_idx;
        state_d   = ST_MOVE_WR;
      end

      ST_MOVE_WR: begin
        mem_we  = 1'b1;
        count_d = count_q - HC_W'(1);
        state_d = ST_IDLE;
      end

      ST_TICK_RD: begin
        mem_re  = 1'b1;
        state_d = ST_TICK_EX;
      end

      ST_TICK_EX: begin
        if (fires && (nfire_q < MAX_FIRE) && pend_v_q && out_busy) begin
          // wait for the receiver before retiring the pending event
          state_d = ST_TICK_EX;
        end else begin
          mem_we        = 1'b1;
          mem_wdata.cnt = fires ? period_q : (rd_q.cnt - CNT_W'(1));
          if (fires && (nfire_q < MAX_FIRE)) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_d      = pend_q;
              out_last_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = '{key: rd_q.key, mods: rd_q.mods};
            nfire_d  = nfire_q + NF_W'(1);
          end
          if (scan_last) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_TICK_RD;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (!out_busy) begin
          out_v_d    = 1'b1;
          out_d      = pend_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      nfire_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      delay_q  <= DELAY_RESET;
      period_q <= PERIOD_RESET;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      nfire_q  <= nfire_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DELAY:  delay_q  <= cfg_data_i;
          CFG_PERIOD: period_q <= cfg_data_i;
          default:    delay_q  <= delay_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rel_key_q  <= rel_key_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.mods, out_q.key};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("held count beyond table size");

  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfire_q <= MAX_FIRE)
    else $error("more events than allowed in one tick");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending event left over after a tick");

  a_press_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_op == OP_PRESS) && in_rep && (count_q < FULL_COUNT))
      |=> (count_q == $past(count_q) + HC_W'(1)))
    else $error("press of repeatable key not appended");

  a_tick_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FLUSH) && pend_v_q && !out_busy) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("final event of a tick not marked last");

endmodule

/* tb/tb.sv */
// Testbench for the held-key repeat timer: directed and random key items checked against a table model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hkrt_pkg::*;

  localparam int unsigned N_ENTRIES     = TABLE_ENTRIES_DEF;
  // release scan plus move-in is the slowest no-result item; settle covers it with margin
  localparam int unsigned SETTLE_CYCLES = 2 * N_ENTRIES + 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  // ~100 items, each up to 8 repeats behind receiver stalls, plus config pauses
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // one expected repeat event
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MODS_W-1:0] mods;
    logic              last;
  } repeat_ev_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic                  cfg_idx  = 1'b0;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  s_valid  = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data   = '0;  // key_code[31:0], key_modifiers[47:32], repeatable[48]
  logic [OP_W-1:0]       s_user   = '0;  // op[1:0]
  logic                  m_valid;
  logic                  m_ready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;         // fired_key[31:0], fired_modifiers[47:32]
  logic                  m_last;

  always #2 clk_i = ~clk_i;

  held_key_repeat_timer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  // ---------------------------------------------------------------------------
  // Held-key table model: own copy of the table and the two timing registers.
  // Updated at the edge where an item is accepted; ticks push their repeats.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]  held_key  [N_ENTRIES];
  logic [MODS_W-1:0] held_mods [N_ENTRIES];
  logic [CNT_W-1:0]  held_cnt  [N_ENTRIES];
  int unsigned       held_n    = 0;
  logic [CNT_W-1:0]  delay_ms  = DELAY_RESET;
  logic [CNT_W-1:0]  period_ms = PERIOD_RESET;
  repeat_ev_t        repeat_q[$];

  function automatic void model_item(op_e op, logic [KEY_W-1:0] key,
                                     logic [MODS_W-1:0] mods, logic rep);
    int unsigned fired;
    int unsigned tail;
    repeat_ev_t  ev;
    fired = 0;
    case (op)
      OP_PRESS: begin
        // non-repeatable keys and presses into a full table are dropped
        if (rep && held_n < N_ENTRIES) begin
          held_key[held_n]  = key;
          held_mods[held_n] = mods;
          held_cnt[held_n]  = delay_ms;
          held_n++;
        end
      end
      OP_RELEASE: begin
        // first match only; the tail entry fills the hole
        for (int i = 0; i < held_n; i++) begin
          if (held_key[i] == key) begin
            tail         = held_n - 1;
            held_key[i]  = held_key[tail];
            held_mods[i] = held_mods[tail];
            held_cnt[i]  = held_cnt[tail];
            held_n       = tail;
            break;
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < held_n; i++) begin
          if (held_cnt[i] <= 1) begin
            held_cnt[i] = period_ms;
            if (fired < MAX_RESULTS) begin
              ev.key  = held_key[i];
              ev.mods = held_mods[i];
              ev.last = 1'b0;
              repeat_q.push_back(ev);
              fired++;
            end
          end else begin
            held_cnt[i] = held_cnt[i] - 1'b1;
          end
        end
        if (fired != 0) begin
          ev      = repeat_q.pop_back();
          ev.last = 1'b1;
          repeat_q.push_back(ev);
        end
      end
      default: begin
        held_n = 0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Failure bookkeeping: first ten are printed, the rest only counted
  // ---------------------------------------------------------------------------
  int unsigned failures = 0;

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Repeat checker: every accepted output item against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    repeat_ev_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (repeat_q.size() == 0) begin
        note_failure($sformatf("unexpected repeat key=%h mods=%h last=%b",
                               m_data[KEY_W-1:0], m_data[KEY_W+:MODS_W], m_last));
      end else begin
        want = repeat_q.pop_front();
        if (m_data[KEY_W-1:0] !== want.key)
          note_failure($sformatf("fired_key exp %h got %h", want.key, m_data[KEY_W-1:0]));
        if (m_data[KEY_W+:MODS_W] !== want.mods)
          note_failure($sformatf("fired_modifiers exp %h got %h (key %h)",
                                 want.mods, m_data[KEY_W+:MODS_W], want.key));
        if (m_last !== want.last)
          note_failure($sformatf("last_fired exp %b got %b (key %h)",
                                 want.last, m_last, want.key));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling control
  // ---------------------------------------------------------------------------
  bit          tx_gaps       = 1'b0;  // sender inserts random gaps
  bit          rx_stalls     = 1'b0;  // receiver drops tready at random
  int unsigned long_hold_req = 0;     // one-shot long receiver hold-off, in cycles
  int unsigned hold_left     = 0;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // receiver: one tready decision per falling edge
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (long_hold_req != 0) begin
      hold_left     = long_hold_req - 1;
      long_hold_req = 0;
      m_ready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
      hold_left = pick_gap() - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // run limit
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // tvalid stays up after an accept; the next call either reloads the data at
  // the next falling edge or drops tvalid there for a gap.
  task automatic send_item(op_e op, logic [KEY_W-1:0] key, logic [MODS_W-1:0] mods,
                           logic rep);
    int unsigned gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= {{(IN_DATA_W - KEY_W - MODS_W - 1){1'b0}}, rep, mods, key};
    do @(posedge clk_i); while (!s_ready);
    model_item(op, key, mods, rep);
  endtask

  // tick with random don't-care payload, so those bits toggle too
  task automatic tick();
    send_item(OP_TICK, $urandom, MODS_W'($urandom), 1'($urandom));
  endtask

  // stop offering, wait for every expected repeat; settle lets a trailing
  // release or press finish before the block is touched
  task automatic wait_drain(bit settle);
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (repeat_q.size() != 0) @(posedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    wait_drain(1'b1);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_DELAY) delay_ms = val;
    else period_ms = val;
  endtask

  task automatic set_timing(logic [CFG_W-1:0] delay, logic [CFG_W-1:0] period);
    write_cfg(CFG_DELAY, delay);
    write_cfg(CFG_PERIOD, period);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // corner cases with the fastest and the slowest timing
  task automatic test_directed();
    // reset timing: nothing may fire on the first tick
    send_item(OP_PRESS, 32'h0000_0042, 16'h0003, 1'b1);
    tick();
    send_item(OP_CLEAR, '0, '0, 1'b0);
    set_timing(16'd1, 16'd1);
    send_item(OP_PRESS, 32'h0000_0001, 16'h0001, 1'b0);  // non-repeatable, dropped
    send_item(OP_PRESS, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    send_item(OP_PRESS, 32'h0000_0000, 16'h0000, 1'b1);
    send_item(OP_PRESS, 32'hFFFF_FFFF, 16'h5A5A, 1'b1);  // duplicate key, own entry
    tick();
    send_item(OP_RELEASE, 32'h1234_5678, '0, 1'b0);      // not held
    send_item(OP_RELEASE, 32'hFFFF_FFFF, '0, 1'b0);      // first match, tail moves in
    tick();
    send_item(OP_CLEAR, '0, '0, 1'b0);
    tick();                                              // empty table
    // fill the table; the ninth press is dropped
    for (int i = 0; i <= N_ENTRIES; i++)
      send_item(OP_PRESS, 32'hA000_0000 + i, MODS_W'(16'h0100 + i), 1'b1);
    tick();                                              // all entries fire
    send_item(OP_RELEASE, 32'hA000_0003, '0, 1'b0);      // middle entry
    tick();
    send_item(OP_CLEAR, '0, '0, 1'b0);
    // longest timing: a held key stays silent
    set_timing(16'hFFFF, 16'hFFFF);
    send_item(OP_PRESS, 32'h8000_0001, 16'h8001, 1'b1);
    tick();
    tick();
    send_item(OP_CLEAR, '0, '0, 1'b0);
  endtask

  // full table firing every tick while the receiver holds off: the output
  // path fills and the block must stall its input
  task automatic test_backpressure();
    set_timing(16'd1, 16'd1);
    for (int i = 0; i < N_ENTRIES; i++)
      send_item(OP_PRESS, $urandom, MODS_W'($urandom), 1'b1);
    long_hold_req = HOLD_CYCLES;
    repeat (10) tick();
    wait_drain(1'b0);          // sender pauses until every repeat is out
    repeat (3) tick();
    send_item(OP_CLEAR, '0, '0, 1'b0);
  endtask

  // random key traffic over several timing settings; releases mostly hit held keys
  task automatic test_random();
    logic [CFG_W-1:0] delay;
    logic [CFG_W-1:0] period;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          delay  = 16'd1;
          period = 16'd1;
        end
        1: begin
          delay  = CFG_W'($urandom_range(2, 6));
          period = CFG_W'($urandom_range(1, 3));
        end
        2: begin
          delay  = CFG_W'($urandom_range(1, 4));
          period = CFG_W'($urandom_range(2, 5));
        end
        default: begin
          delay  = CFG_W'($urandom_range(3, 8));
          period = 16'd1;
        end
      endcase
      set_timing(delay, period);
      // first phase runs without idling on either side
      tx_gaps   = (phase != 0);
      rx_stalls = (phase != 0);
      repeat (12) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
          send_item(OP_PRESS, $urandom, MODS_W'($urandom), ($urandom_range(0, 7) != 0));
        end else if (pick < 9) begin
          key = (held_n != 0 && pick != 8) ? held_key[$urandom_range(0, held_n - 1)]
                                           : KEY_W'($urandom);
          send_item(OP_RELEASE, key, MODS_W'($urandom), 1'($urandom));
        end else if (pick < 19) begin
          tick();
        end else begin
          send_item(OP_CLEAR, $urandom, MODS_W'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    wait_drain(1'b1);
    failures += repeat_q.size();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
